/* hdl/ssm_pkg.sv */
package ssm_pkg;

    localparam int DATA_BITS  = 32;
    localparam int COUNT_BITS = 6;
    localparam int LANES      = 4;
    localparam int CS_BITS    = 3;

    localparam logic [1:0] ACT_SELECT = 2'd0;
    localparam logic [1:0] ACT_START  = 2'd1;
    localparam logic [1:0] ACT_TICK   = 2'd2;

    localparam logic [1:0] DIR_WRITE = 2'd0;
    localparam logic [1:0] DIR_READ  = 2'd1;
    localparam logic [1:0] DIR_RW    = 2'd2;

    localparam logic [1:0] DEV_SRAM  = 2'd1;
    localparam logic [1:0] DEV_FLASH = 2'd2;

    localparam int HOLD_LANE = 3;
    localparam int MISO_LANE = 1;

    typedef struct packed {
        logic [1:0]            action;
        logic [1:0]            device;
        logic                  select;
        logic [1:0]            direction;
        logic                  quad;
        logic [COUNT_BITS-1:0] bit_count;
        logic [DATA_BITS-1:0]  tx_data;
        logic [LANES-1:0]      lanes_in;
    } t_item;

    typedef struct packed {
        logic [LANES-1:0]     lanes_out;
        logic                 clock_pulsed;
        logic [CS_BITS-1:0]   chip_selects_n;
        logic [DATA_BITS-1:0] read_word;
        logic                 busy_res;
        logic                 done_res;
    } t_result;

endpackage

/* hdl/ssm_in_reg.sv */
module ssm_in_reg
    import ssm_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_item i_item,
    output logic  o_valid,
    output t_item o_item,
    input  logic  i_take
);

    logic  r_valid;
    t_item r_item;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

endmodule

/* hdl/ssm_core.sv */
module ssm_core
    import ssm_pkg::*;
#(
    parameter int WORD_BITS    = 32,
    parameter int DEVICE_COUNT = 3
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_adv,
    input  t_item   i_item,
    output t_result o_res
);

    localparam int CW = $clog2(WORD_BITS + 1);
    localparam int PW = $clog2(WORD_BITS);
    localparam int EW = (WORD_BITS > DATA_BITS) ? WORD_BITS : DATA_BITS;
    localparam int SW = (DEVICE_COUNT > CS_BITS) ? DEVICE_COUNT : CS_BITS;

    logic [WORD_BITS-1:0]    r_shift, n_shift;
    logic [CW-1:0]           r_left, n_left;
    logic [WORD_BITS-1:0]    r_accum, n_accum;
    logic [1:0]              r_dir, n_dir;
    logic                    r_quad, n_quad;
    logic [LANES-1:0]        r_lanes, n_lanes;
    logic [DEVICE_COUNT-1:0] r_sel, n_sel;

    logic [CW-1:0]    cnt_sat, cnt_ld, step, left_dec;
    logic [1:0]       dir_ld;
    logic [PW-1:0]    pos;
    logic [LANES-1:0] window, period;
    logic             drives, samples, pulsed, done;
    logic [EW-1:0]    tx_ext, acc_ext;
    logic [SW-1:0]    sel_ext;

    always_comb begin
        n_shift = r_shift;
        n_left  = r_left;
        n_accum = r_accum;
        n_dir   = r_dir;
        n_quad  = r_quad;
        n_lanes = r_lanes;
        n_sel   = r_sel;
        pulsed  = 1'b0;
        done    = 1'b0;
        period  = r_lanes;

        cnt_sat = (int'(i_item.bit_count) > WORD_BITS) ? CW'(WORD_BITS)
                                                       : CW'(i_item.bit_count);
        cnt_ld  = i_item.quad ? (cnt_sat & ~CW'(3)) : cnt_sat;
        dir_ld  = i_item.direction;
        if (!(dir_ld == DIR_READ || dir_ld == DIR_RW) || (i_item.quad && dir_ld == DIR_RW)) begin
            dir_ld = DIR_WRITE;
        end
        tx_ext = EW'(i_item.tx_data);

        step     = r_quad ? CW'(LANES) : CW'(1);
        left_dec = r_left - step;
        pos      = left_dec[PW-1:0];
        window   = LANES'(r_shift >> pos);
        drives   = (r_dir == DIR_WRITE) || (r_dir == DIR_RW);
        samples  = (r_dir == DIR_READ) || (r_dir == DIR_RW);

        case (i_item.action)
            ACT_SELECT: begin
                if (int'(i_item.device) < DEVICE_COUNT) begin
                    for (int d = 0; d < DEVICE_COUNT; d++) begin
                        if (int'(i_item.device) == d) begin
                            n_sel[d] = !i_item.select;
                        end
                    end
                    if (i_item.select && !i_item.quad &&
                        (i_item.device == DEV_SRAM || i_item.device == DEV_FLASH)) begin
                        n_lanes[HOLD_LANE] = 1'b1;
                    end
                end
                period = n_lanes;
            end
            ACT_START: begin
                n_dir   = dir_ld;
                n_quad  = i_item.quad;
                n_left  = cnt_ld;
                n_shift = tx_ext[WORD_BITS-1:0] & ~({WORD_BITS{1'b1}} << cnt_ld);
                n_accum = '0;
            end
            ACT_TICK: begin
                if (r_left != '0) begin
                    pulsed = 1'b1;
                    if (!r_quad) begin
                        if (drives) begin
                            n_lanes[0] = r_shift[pos];
                        end
                        if (samples && i_item.lanes_in[MISO_LANE]) begin
                            n_accum = r_accum | (WORD_BITS'(1) << pos);
                        end
                    end else begin
                        if (drives) begin
                            n_lanes = window;
                        end
                        if (samples) begin
                            n_accum = r_accum | (WORD_BITS'(i_item.lanes_in) << pos);
                        end
                    end
                    n_left = left_dec;
                    period = n_lanes;
                    if (left_dec == '0) begin
                        done    = 1'b1;
                        n_lanes = r_quad ? '0 : {n_lanes[LANES-1:1], 1'b0};
                    end
                end
            end
            default: ;
        endcase

        acc_ext = EW'(n_accum);
        sel_ext = SW'(n_sel);

        o_res.lanes_out      = period;
        o_res.clock_pulsed   = pulsed;
        o_res.chip_selects_n = sel_ext[CS_BITS-1:0];
        o_res.read_word      = acc_ext[DATA_BITS-1:0];
        o_res.busy_res       = (n_left != '0);
        o_res.done_res       = done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift <= '0;
            r_left  <= '0;
            r_accum <= '0;
            r_dir   <= DIR_WRITE;
            r_quad  <= 1'b0;
            r_lanes <= '0;
            r_sel   <= '1;
        end else if (i_adv) begin
            r_shift <= n_shift;
            r_left  <= n_left;
            r_accum <= n_accum;
            r_dir   <= n_dir;
            r_quad  <= n_quad;
            r_lanes <= n_lanes;
            r_sel   <= n_sel;
        end
    end

endmodule

/* hdl/ssm_out_reg.sv */
module ssm_out_reg
    import ssm_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_take,
    input  t_result i_res,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_res
);

    logic    r_valid;
    t_result r_res;

    assign o_take  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_take) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && i_valid) begin
            r_res <= i_res;
        end
    end

endmodule

/* hdl/spi_sqi_shift_master_top.sv */
// Serial master for single-lane and four-lane transfers, one request at a time.
// Input channel (i_valid/o_ready) carries a request: a chip select change, a
// transfer start (word, bit count, direction, lane mode) or one clock-period
// tick. Output channel (o_valid/i_ready) returns exactly one result per
// request: driven lane levels, clock pulse flag, chip selects, read word,
// busy and done.
// Pipeline: an accepted request goes into the input register, then into the
// result register, whose contents drive the output.
// Throughput: one request per cycle while i_ready is high; the shift
// state updates in a single pass between the input and result registers.
// Reset: i_rst_n low at a clock edge empties both registers, clears the
// shift word, count, read word and lanes, and raises every chip select.
// Stall: while i_ready is low the result holds; one more request is taken
// into the input register, after which o_ready drops until the result goes.
module spi_sqi_shift_master_top
    import ssm_pkg::*;
#(
    parameter int WORD_BITS    = 32,
    parameter int DEVICE_COUNT = 3
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [1:0]            i_action,
    input  logic [1:0]            i_device,
    input  logic                  i_select,
    input  logic [1:0]            i_direction,
    input  logic                  i_quad,
    input  logic [COUNT_BITS-1:0] i_bit_count,
    input  logic [DATA_BITS-1:0]  i_tx_data,
    input  logic [LANES-1:0]      i_lanes_in,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [LANES-1:0]      o_lanes_out,
    output logic                  o_clock_pulsed,
    output logic [CS_BITS-1:0]    o_chip_selects_n,
    output logic [DATA_BITS-1:0]  o_read_word,
    output logic                  o_busy_res,
    output logic                  o_done_res
);

    t_item   in_item, st_item;
    t_result core_res, out_res;
    logic    st_valid, take, adv;

    assign in_item.action    = i_action;
    assign in_item.device    = i_device;
    assign in_item.select    = i_select;
    assign in_item.direction = i_direction;
    assign in_item.quad      = i_quad;
    assign in_item.bit_count = i_bit_count;
    assign in_item.tx_data   = i_tx_data;
    assign in_item.lanes_in  = i_lanes_in;

    assign adv = st_valid && take;

    ssm_in_reg u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_item  (in_item),
        .o_valid (st_valid),
        .o_item  (st_item),
        .i_take  (take)
    );

    ssm_core #(
        .WORD_BITS    (WORD_BITS),
        .DEVICE_COUNT (DEVICE_COUNT)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_item  (st_item),
        .o_res   (core_res)
    );

    ssm_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (st_valid),
        .o_take  (take),
        .i_res   (core_res),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_res   (out_res)
    );

    assign o_lanes_out      = out_res.lanes_out;
    assign o_clock_pulsed   = out_res.clock_pulsed;
    assign o_chip_selects_n = out_res.chip_selects_n;
    assign o_read_word      = out_res.read_word;
    assign o_busy_res       = out_res.busy_res;
    assign o_done_res       = out_res.done_res;

`ifndef NO_ASSERTIONS
    a_done_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_done_res) |-> (!o_busy_res && o_clock_pulsed))
        else $error("done without pulse or with bits left");

    a_adv_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv |=> o_valid)
        else $error("advanced request did not reach the result register");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_valid && !st_valid))
        else $error("request survived reset");
`endif

endmodule
